// ----- src/ir_instruction_executor_assert.svh -----
// Assertion macros shared by the instruction executor modules.
// Define NO_ASSERTIONS to compile them out.
`ifndef IR_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define IR_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// ante |-> cons, checked on every rising edge outside reset
`define IRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ir executor assertion failed");
// ante |=> cons, checked on every rising edge outside reset
`define IRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ir executor assertion failed");
`else
`define IRE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define IRE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/ire_pkg.sv -----
// ----------------------------------------------------------------------------
// IR executor package
// Instruction codes, status codes and controller state type.
// ----------------------------------------------------------------------------
package ire_pkg;

    localparam int DATA_W = 32;

    // instruction types
    localparam logic [2:0] ACT_NOOP   = 3'd0;
    localparam logic [2:0] ACT_IN     = 3'd1;
    localparam logic [2:0] ACT_OUT    = 3'd2;
    localparam logic [2:0] ACT_ASSIGN = 3'd3;
    localparam logic [2:0] ACT_CJMP   = 3'd4;
    localparam logic [2:0] ACT_JMP    = 3'd5;

    // assign operators
    localparam logic [2:0] OP_COPY  = 3'd0;
    localparam logic [2:0] OP_PLUS  = 3'd1;
    localparam logic [2:0] OP_MINUS = 3'd2;
    localparam logic [2:0] OP_MULT  = 3'd3;
    localparam logic [2:0] OP_DIV   = 3'd4;

    // branch conditions
    localparam logic [1:0] CMP_GT = 2'd0;
    localparam logic [1:0] CMP_LT = 2'd1;
    localparam logic [1:0] CMP_NE = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_INPUT  = 3'd1;
    localparam logic [2:0] ST_DIV_ZERO  = 3'd2;
    localparam logic [2:0] ST_BAD_OP    = 3'd3;
    localparam logic [2:0] ST_BAD_COND  = 3'd4;
    localparam logic [2:0] ST_NO_TARGET = 3'd5;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd6;
    localparam logic [2:0] ST_HALTED    = 3'd7;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_EXEC,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- src/ire_divider.sv -----
// ----------------------------------------------------------------------------
// IR executor divider
// Signed truncating divide, radix 2, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "ir_instruction_executor_assert.svh"

module ire_divider (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [ire_pkg::DATA_W-1:0]  i_dividend,
    input  logic signed [ire_pkg::DATA_W-1:0]  i_divisor,
    output logic                               o_done,
    output logic signed [ire_pkg::DATA_W-1:0]  o_quotient
);

    localparam int DW = ire_pkg::DATA_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_dvs;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic          r_active;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;
    logic          w_ge;

    assign w_shift = {r_rem, r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                // work on magnitudes, fix the sign at the end
                r_rem    <= '0;
                r_quo    <= i_dividend[DW-1] ? DW'(-i_dividend) : DW'(i_dividend);
                r_dvs    <= i_divisor[DW-1] ? DW'(-i_divisor) : DW'(i_divisor);
                r_neg    <= i_dividend[DW-1] ^ i_divisor[DW-1];
                r_cnt    <= '0;
                r_active <= 1'b1;
            end else if (r_active) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_quo <= {r_quo[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quo) : $signed(r_quo);

    `IRE_ASSERT_IMP(a_done_after_run, i_clk, i_rst_n, o_done, $past(r_active))
    `IRE_ASSERT_IMP(a_no_done_while_run, i_clk, i_rst_n, r_active, !o_done)
    `IRE_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_start, r_active)

endmodule

// ----- src/ir_instruction_executor.sv -----
// An accepted start passes through the address, execute and done states before the
// o_done strobe; a divide waits for the radix-2 divider, one quotient bit per cycle.
// One instruction is in flight at a time; start is taken again in the strobe cycle.
// Results appear for one cycle on o_done and cannot be held off by the receiver.
// After reset a clearing pass zeroes the variable memory,
// with busy high throughout; the sticky halt flag is cleared by reset.
// ----------------------------------------------------------------------------
// IR instruction executor
// Runs one three-address instruction per command against a variable memory.
// ----------------------------------------------------------------------------
`include "ir_instruction_executor_assert.svh"

module ir_instruction_executor #(
    parameter int MEMORY_WORDS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_action,
    input  logic [2:0]                         i_arith_op,
    input  logic [1:0]                         i_compare_op,
    input  logic [9:0]                         i_dest_index,
    input  logic [9:0]                         i_first_index,
    input  logic [9:0]                         i_second_index,
    input  logic signed [ire_pkg::DATA_W-1:0]  i_input_value,
    input  logic                               i_input_present,
    input  logic                               i_target_present,
    output logic                               o_done,
    output logic signed [ire_pkg::DATA_W-1:0]  o_out_value,
    output logic                               o_out_valid,
    output logic                               o_branch_taken,
    output logic [2:0]                         o_status
);

    localparam int DW = ire_pkg::DATA_W;
    localparam int AW = (MEMORY_WORDS > 1) ? $clog2(MEMORY_WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(MEMORY_WORDS - 1);

    ire_pkg::t_state r_state, n_state;

    logic                 r_halted;
    logic [AW-1:0]        r_clear_cnt;

    // latched command
    logic [2:0]           r_action;
    logic [2:0]           r_arith_op;
    logic [1:0]           r_compare_op;
    logic [9:0]           r_dest_index;
    logic [9:0]           r_first_index;
    logic [9:0]           r_second_index;
    logic signed [DW-1:0] r_input_value;
    logic                 r_input_present;
    logic                 r_target_present;

    logic [AW-1:0]        w_addr_dest;
    logic [AW-1:0]        w_addr_first;
    logic [AW-1:0]        w_addr_second;
    logic [AW-1:0]        r_dest_addr;

    // variable memory
    logic signed [DW-1:0] r_mem [MEMORY_WORDS];
    logic signed [DW-1:0] r_rd_a;
    logic signed [DW-1:0] r_rd_b;
    logic                 w_mem_re;
    logic                 w_mem_we;
    logic [AW-1:0]        w_mem_waddr;
    logic signed [DW-1:0] w_mem_wdata;

    // execute results
    logic signed [DW-1:0] r_result;
    logic [2:0]           r_status;
    logic                 r_wr_en;
    logic                 r_out_valid;
    logic                 r_taken;

    logic signed [DW-1:0] n_result;
    logic [2:0]           n_status;
    logic                 n_wr_en;
    logic                 n_out_valid;
    logic                 n_taken;
    logic                 w_is_div;
    logic signed [DW-1:0] w_prod;

    logic                 w_accept;
    logic                 w_div_start;
    logic                 w_div_done;
    logic signed [DW-1:0] w_div_quot;

    assign w_accept = start && !busy;

    // ---------------------------------------------------------------- index fold
    if (MEMORY_WORDS >= 1024) begin : g_direct
        assign w_addr_dest   = AW'(r_dest_index);
        assign w_addr_first  = AW'(r_first_index);
        assign w_addr_second = AW'(r_second_index);
    end else begin : g_fold
        // idx mod M via a reciprocal: q = (idx * ceil(2^20/M)) >> 20 is exact for idx < 1024
        localparam logic [20:0] RECIP = 21'(((1 << 20) + MEMORY_WORDS - 1) / MEMORY_WORDS);
        localparam logic [9:0]  WORDS = 10'(MEMORY_WORDS);

        logic [30:0] w_prod_dest;
        logic [30:0] w_prod_first;
        logic [30:0] w_prod_second;
        logic [9:0]  r_quot_dest;
        logic [9:0]  r_quot_first;
        logic [9:0]  r_quot_second;

        assign w_prod_dest   = 31'(i_dest_index) * 31'(RECIP);
        assign w_prod_first  = 31'(i_first_index) * 31'(RECIP);
        assign w_prod_second = 31'(i_second_index) * 31'(RECIP);

        always_ff @(posedge i_clk) begin
            if (w_accept) begin
                r_quot_dest   <= w_prod_dest[29:20];
                r_quot_first  <= w_prod_first[29:20];
                r_quot_second <= w_prod_second[29:20];
            end
        end

        assign w_addr_dest   = AW'(r_dest_index - 10'(r_quot_dest * WORDS));
        assign w_addr_first  = AW'(r_first_index - 10'(r_quot_first * WORDS));
        assign w_addr_second = AW'(r_second_index - 10'(r_quot_second * WORDS));
    end

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rd_a <= r_mem[w_addr_first];
            r_rd_b <= r_mem[w_addr_second];
        end
    end

    // ---------------------------------------------------------------- execute
    assign w_prod = r_rd_a * r_rd_b;

    always_comb begin
        n_result    = '0;
        n_status    = ire_pkg::ST_OK;
        n_wr_en     = 1'b0;
        n_out_valid = 1'b0;
        n_taken     = 1'b0;
        w_is_div    = 1'b0;
        if (r_halted) begin
            n_status = ire_pkg::ST_HALTED;
        end else begin
            case (r_action)
                ire_pkg::ACT_NOOP: begin
                end
                ire_pkg::ACT_IN: begin
                    if (r_input_present) begin
                        n_result = r_input_value;
                        n_wr_en  = 1'b1;
                    end else begin
                        n_status = ire_pkg::ST_NO_INPUT;
                    end
                end
                ire_pkg::ACT_OUT: begin
                    n_result    = r_rd_a;
                    n_out_valid = 1'b1;
                end
                ire_pkg::ACT_ASSIGN: begin
                    case (r_arith_op)
                        ire_pkg::OP_COPY: begin
                            n_result = r_rd_a;
                            n_wr_en  = 1'b1;
                        end
                        ire_pkg::OP_PLUS: begin
                            n_result = r_rd_a + r_rd_b;
                            n_wr_en  = 1'b1;
                        end
                        ire_pkg::OP_MINUS: begin
                            n_result = r_rd_a - r_rd_b;
                            n_wr_en  = 1'b1;
                        end
                        ire_pkg::OP_MULT: begin
                            n_result = w_prod;
                            n_wr_en  = 1'b1;
                        end
                        ire_pkg::OP_DIV: begin
                            if (r_rd_b == '0) begin
                                n_status = ire_pkg::ST_DIV_ZERO;
                            end else begin
                                // quotient arrives from the divider
                                w_is_div = 1'b1;
                                n_wr_en  = 1'b1;
                            end
                        end
                        default: begin
                            n_status = ire_pkg::ST_BAD_OP;
                        end
                    endcase
                end
                ire_pkg::ACT_CJMP: begin
                    if (!r_target_present) begin
                        n_status = ire_pkg::ST_NO_TARGET;
                    end else begin
                        case (r_compare_op)
                            ire_pkg::CMP_GT: n_taken = r_rd_a > r_rd_b;
                            ire_pkg::CMP_LT: n_taken = r_rd_a < r_rd_b;
                            ire_pkg::CMP_NE: n_taken = r_rd_a != r_rd_b;
                            default:         n_status = ire_pkg::ST_BAD_COND;
                        endcase
                    end
                end
                ire_pkg::ACT_JMP: begin
                    if (r_target_present) begin
                        n_taken = 1'b1;
                    end else begin
                        n_status = ire_pkg::ST_NO_TARGET;
                    end
                end
                default: begin
                    n_status = ire_pkg::ST_BAD_TYPE;
                end
            endcase
        end
    end

    ire_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rd_a),
        .i_divisor  (r_rd_b),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    // ---------------------------------------------------------------- control
    always_comb begin
        n_state = r_state;
        case (r_state)
            ire_pkg::S_CLEAR: begin
                if (r_clear_cnt == LAST_WORD) begin
                    n_state = ire_pkg::S_IDLE;
                end
            end
            ire_pkg::S_IDLE: begin
                if (start) begin
                    n_state = ire_pkg::S_ADDR;
                end
            end
            ire_pkg::S_ADDR: n_state = ire_pkg::S_EXEC;
            ire_pkg::S_EXEC: n_state = w_is_div ? ire_pkg::S_DIV : ire_pkg::S_DONE;
            ire_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = ire_pkg::S_DONE;
                end
            end
            ire_pkg::S_DONE: n_state = ire_pkg::S_IDLE;
            default:         n_state = ire_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        busy        = 1'b1;
        w_mem_re    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_dest_addr;
        w_mem_wdata = r_result;
        w_div_start = 1'b0;
        case (r_state)
            ire_pkg::S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clear_cnt;
                w_mem_wdata = '0;
            end
            ire_pkg::S_IDLE: busy = 1'b0;
            ire_pkg::S_ADDR: w_mem_re = 1'b1;
            ire_pkg::S_EXEC: w_div_start = w_is_div;
            ire_pkg::S_DIV: begin
            end
            ire_pkg::S_DONE: w_mem_we = r_wr_en;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ire_pkg::S_CLEAR;
            r_clear_cnt <= '0;
            r_halted    <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            if (r_state == ire_pkg::S_CLEAR) begin
                r_clear_cnt <= r_clear_cnt + 1'b1;
            end
            if (r_state == ire_pkg::S_DONE) begin
                o_done <= 1'b1;
                if (r_status != ire_pkg::ST_OK) begin
                    r_halted <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action         <= i_action;
            r_arith_op       <= i_arith_op;
            r_compare_op     <= i_compare_op;
            r_dest_index     <= i_dest_index;
            r_first_index    <= i_first_index;
            r_second_index   <= i_second_index;
            r_input_value    <= i_input_value;
            r_input_present  <= i_input_present;
            r_target_present <= i_target_present;
        end
        if (r_state == ire_pkg::S_ADDR) begin
            r_dest_addr <= w_addr_dest;
        end
        if (r_state == ire_pkg::S_EXEC) begin
            r_result    <= n_result;
            r_status    <= n_status;
            r_wr_en     <= n_wr_en;
            r_out_valid <= n_out_valid;
            r_taken     <= n_taken;
        end
        if (r_state == ire_pkg::S_DIV && w_div_done) begin
            r_result <= w_div_quot;
        end
        if (r_state == ire_pkg::S_DONE) begin
            o_out_value    <= r_out_valid ? r_result : '0;
            o_out_valid    <= r_out_valid;
            o_branch_taken <= r_taken;
            o_status       <= r_status;
        end
    end

    `IRE_ASSERT_IMP(a_done_when_idle, i_clk, i_rst_n, o_done, !busy)
    `IRE_ASSERT_IMP(a_out_only_ok, i_clk, i_rst_n, o_done && o_out_valid, o_status == ire_pkg::ST_OK)
    `IRE_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, o_done && o_status != ire_pkg::ST_OK, r_halted)
    `IRE_ASSERT_IMP(a_div_only_for_div, i_clk, i_rst_n, r_state == ire_pkg::S_DIV, r_action == ire_pkg::ACT_ASSIGN && r_arith_op == ire_pkg::OP_DIV)

endmodule
